// ===== rtl/sde_pkg.sv =====
// Shared types, constants and the gain table function of the stereo de-esser.
// Depends on nothing; every other file of the block imports it.
package sde_pkg;

  // Sample and coefficient formats.
  localparam int SAMPLE_BITS = 24;
  localparam int COEF_W      = 32;
  localparam int ACC_W       = 60;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 3;

  // Default values of the top-level parameters.
  localparam int DEF_UPDATE_INTERVAL = 8;
  localparam int DEF_ATTACK_COEF     = 16701300;
  localparam int DEF_RELEASE_COEF    = 16769600;

  // 10^(-1/400) in Q2.30, one twentieth of a dB of cut per power.
  localparam logic [63:0] GAIN_STEP_Q30 = 64'd1067578625;
  localparam logic [COEF_W-1:0] ONE_Q30 = 32'h4000_0000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SC_B0     = 3'd0,
    REG_SC_A1     = 3'd1,
    REG_SC_A2     = 3'd2,
    REG_COS_OMEGA = 3'd3,
    REG_ALPHA     = 3'd4,
    REG_THRESHOLD = 3'd5,
    REG_MAX_CUT   = 3'd6
  } reg_idx_e;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [4:0][COEF_W-1:0] coef_set_t;

  // Pass-through filter: b0 is one, the rest zero.
  localparam coef_set_t COEF_RESET = {128'd0, ONE_Q30};

  // Lane control and lane status.
  typedef struct packed {
    logic start;
    logic main_sel;
  } lane_ctl_t;

  typedef struct packed {
    logic    done;
    sample_t y;
  } lane_res_t;

  // Gain step raised to the power 2^k, squared with rounding as the
  // square-and-multiply sequence does it.
  function automatic logic [29:0] gain_base(int k);
    logic [63:0] b;
    b = GAIN_STEP_Q30;
    for (int i = 0; i < k; i++) begin
      b = (b * b + 64'd536870912) >> 30;
    end
    return b[29:0];
  endfunction

endpackage

// ===== rtl/sde_if.sv =====
// Request and result channel interfaces of the stereo de-esser.
// Depends on sde_pkg for the sample type.
interface sde_in_if import sde_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_left;
  sample_t sample_right;

  modport source(output valid, output sample_left, output sample_right, input ready);
  modport sink(input valid, input sample_left, input sample_right, output ready);
endinterface

interface sde_out_if import sde_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t out_left;
  sample_t out_right;

  modport source(output valid, output out_left, output out_right, input ready);
  modport sink(input valid, input out_left, input out_right, output ready);
endinterface

// ===== rtl/sde_lane.sv =====
// One channel lane: a five-tap multiply-accumulate biquad shared by the
// sidechain high-pass and the main peaking filter. Depends on sde_pkg.
module sde_lane import sde_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lane_ctl_t ctl_i,
  input  coef_set_t sc_coef_i,
  input  coef_set_t mn_coef_i,
  input  sample_t   x_i,
  output lane_res_t res_o
);

  typedef enum logic [2:0] {
    L_IDLE = 3'b001,
    L_RUN  = 3'b010,
    L_FIN  = 3'b100
  } lane_state_e;

  localparam logic [2:0] LAST_TAP = 3'd4;
  localparam logic signed [ACC_W-1:0] HALF29 = ACC_W'(64'd268435456);
  localparam logic signed [ACC_W-1:0] HALF30 = ACC_W'(64'd536870912);
  localparam logic signed [ACC_W-1:0] S_MAX = ACC_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic signed [ACC_W-1:0] S_MIN = -S_MAX - ACC_W'(1);

  lane_state_e state_q, state_d;
  logic [2:0] tap_q, tap_d;
  logic main_q, main_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  sample_t sc_h_q [4];
  sample_t mn_h_q [4];
  sample_t y_q;
  logic done_q;

  sample_t d_sel;
  logic signed [COEF_W-1:0] c_sel;
  logic signed [COEF_W+SAMPLE_BITS-1:0] prod;
  logic signed [ACC_W-1:0] rnd;
  sample_t y_d;

  // Tap operand selection and the product for the current tap.
  always_comb begin
    case (tap_q)
      3'd0:    d_sel = x_i;
      3'd1:    d_sel = main_q ? mn_h_q[0] : sc_h_q[0];
      3'd2:    d_sel = main_q ? mn_h_q[1] : sc_h_q[1];
      3'd3:    d_sel = main_q ? mn_h_q[2] : sc_h_q[2];
      3'd4:    d_sel = main_q ? mn_h_q[3] : sc_h_q[3];
      default: d_sel = '0;
    endcase
    c_sel = $signed(main_q ? mn_coef_i[tap_q] : sc_coef_i[tap_q]);
    prod  = c_sel * d_sel;
  end

  // Rounding by the coefficient format and saturation to a sample.
  always_comb begin
    if (main_q) begin
      rnd = (acc_q + HALF30) >>> 30;
    end else begin
      rnd = (acc_q + HALF29) >>> 29;
    end
    if (rnd > S_MAX) begin
      y_d = SAMPLE_BITS'(S_MAX);
    end else if (rnd < S_MIN) begin
      y_d = SAMPLE_BITS'(S_MIN);
    end else begin
      y_d = SAMPLE_BITS'(rnd);
    end
  end

  // Sequencer over the five taps.
  always_comb begin
    state_d = state_q;
    tap_d   = tap_q;
    main_d  = main_q;
    acc_d   = acc_q;
    unique case (state_q)
      L_IDLE: begin
        if (ctl_i.start) begin
          state_d = L_RUN;
          tap_d   = '0;
          main_d  = ctl_i.main_sel;
          acc_d   = '0;
        end
      end
      L_RUN: begin
        if (tap_q >= 3'd3) begin
          acc_d = acc_q - ACC_W'(prod);
        end else begin
          acc_d = acc_q + ACC_W'(prod);
        end
        tap_d = tap_q + 3'd1;
        if (tap_q == LAST_TAP) begin
          state_d = L_FIN;
        end
      end
      L_FIN: begin
        state_d = L_IDLE;
      end
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      tap_q   <= '0;
      main_q  <= 1'b0;
      done_q  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        sc_h_q[i] <= '0;
        mn_h_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
      main_q  <= main_d;
      done_q  <= (state_q == L_FIN);
      // History shift at the end of each filter pass.
      if (state_q == L_FIN) begin
        if (main_q) begin
          mn_h_q[1] <= mn_h_q[0];
          mn_h_q[0] <= x_i;
          mn_h_q[3] <= mn_h_q[2];
          mn_h_q[2] <= y_d;
        end else begin
          sc_h_q[1] <= sc_h_q[0];
          sc_h_q[0] <= x_i;
          sc_h_q[3] <= sc_h_q[2];
          sc_h_q[2] <= y_d;
        end
      end
    end
  end

  // Accumulator and result payload.
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (state_q == L_FIN) begin
      y_q <= y_d;
    end
  end

  assign res_o.done = done_q;
  assign res_o.y    = y_q;

endmodule

// ===== rtl/sde_merge.sv =====
// Merging stage: takes the larger sidechain magnitude of the two lanes and
// runs the attack/release peak envelope. Depends on sde_pkg.
module sde_merge import sde_pkg::*; #(
  parameter int ATTACK_COEF  = DEF_ATTACK_COEF,
  parameter int RELEASE_COEF = DEF_RELEASE_COEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  sample_t                yl_i,
  input  sample_t                yr_i,
  output logic [SAMPLE_BITS-1:0] env_o
);

  localparam int EW = SAMPLE_BITS;
  localparam logic signed [EW:0] ATK = $signed({1'b0, EW'(ATTACK_COEF)});
  localparam logic signed [EW:0] REL = $signed({1'b0, EW'(RELEASE_COEF)});
  localparam logic signed [EW+2:0] ENV_MAX = (EW+3)'(64'd1 << (SAMPLE_BITS - 1));
  localparam logic signed [2*EW+1:0] HALF24 = (2*EW+2)'(64'd8388608);

  logic [EW-1:0] env_q, env_d;
  logic [EW-1:0] mag_l, mag_r, lvl;
  logic signed [EW:0] diff, coef;
  logic signed [2*EW+1:0] prod;
  logic signed [2*EW+1:0] step;
  logic signed [EW+2:0] nv;

  // Level detection and envelope smoothing.
  always_comb begin
    mag_l = yl_i[EW-1] ? EW'(-yl_i) : EW'(yl_i);
    mag_r = yr_i[EW-1] ? EW'(-yr_i) : EW'(yr_i);
    lvl   = (mag_r > mag_l) ? mag_r : mag_l;
    diff  = $signed({1'b0, env_q}) - $signed({1'b0, lvl});
    coef  = (lvl > env_q) ? ATK : REL;
    prod  = coef * diff;
    step  = (prod + HALF24) >>> 24;
    nv    = $signed({3'b000, lvl}) + (EW+3)'(step);
    if (nv < 0) begin
      env_d = '0;
    end else if (nv > ENV_MAX) begin
      env_d = EW'(ENV_MAX);
    end else begin
      env_d = EW'(nv);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q <= '0;
    end else if (en_i) begin
      env_q <= env_d;
    end
  end

  assign env_o = env_q;

endmodule

// ===== rtl/sde_coef.sv =====
// Coefficient unit: cut depth, gain by square and multiply, then four
// bit-serial restoring divisions into the active main filter set.
// Depends on sde_pkg.
module sde_coef import sde_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [SAMPLE_BITS-1:0] env_i,
  input  logic [23:0]            thr_i,
  input  logic [8:0]             max_cut_i,
  input  logic [30:0]            alpha_i,
  input  logic [31:0]            cos_i,
  output coef_set_t              coef_o,
  output logic                   done_o
);

  typedef enum logic [8:0] {
    C_IDLE   = 9'b000000001,
    C_CUT    = 9'b000000010,
    C_POW    = 9'b000000100,
    C_SQ     = 9'b000001000,
    C_AA2    = 9'b000010000,
    C_CSA    = 9'b000100000,
    C_DLOAD  = 9'b001000000,
    C_DIV    = 9'b010000000,
    C_DSTORE = 9'b100000000
  } coef_state_e;

  localparam int DIV_STEPS = 65;
  localparam logic [29:0] BASE_TAB [9] = '{
    gain_base(0), gain_base(1), gain_base(2), gain_base(3), gain_base(4),
    gain_base(5), gain_base(6), gain_base(7), gain_base(8)
  };
  localparam logic signed [65:0] HALF30 = 66'sd536870912;
  localparam logic signed [65:0] HALF27 = 66'sd67108864;

  coef_state_e state_q;
  coef_set_t coef_q;
  logic done_q;
  logic [8:0] cut_q;
  logic [3:0] k_q;
  logic [30:0] a_q, a2_q;
  logic [34:0] aa2_q;
  logic signed [32:0] csa_q;
  logic [1:0] j_q;
  logic [64:0] dvd_q;
  logic [34:0] rem_q;
  logic [32:0] q_q;
  logic ovf_q, neg_q;
  logic [6:0] cnt_q;

  logic signed [32:0] mop_a, mop_b;
  logic signed [65:0] prod, rnd30, rnd27;
  logic [24:0] ediff;
  logic [26:0] r4;
  logic [23:0] rc;
  logic [33:0] cutp;
  logic signed [36:0] n_sel, n_abs;
  logic [34:0] den, den_nz;
  logic [35:0] rem2;
  logic ge, up;
  logic [33:0] qr;
  logic [31:0] cval;

  // Shared multiplier, operands chosen by the step in progress.
  always_comb begin
    unique case (state_q)
      C_POW: begin
        mop_a = $signed({2'b00, a_q});
        mop_b = $signed({3'b000, BASE_TAB[k_q]});
      end
      C_SQ: begin
        mop_a = $signed({2'b00, a_q});
        mop_b = $signed({2'b00, a_q});
      end
      C_AA2: begin
        mop_a = $signed({2'b00, alpha_i});
        mop_b = $signed({2'b00, a2_q});
      end
      C_CSA: begin
        mop_a = $signed({cos_i[31], cos_i});
        mop_b = $signed({2'b00, a_q});
      end
      default: begin
        mop_a = '0;
        mop_b = '0;
      end
    endcase
    prod  = mop_a * mop_b;
    rnd30 = (prod + HALF30) >>> 30;
    rnd27 = (prod + HALF27) >>> 27;
  end

  // Cut depth from the envelope excess over the threshold.
  always_comb begin
    ediff = {1'b0, env_i} - {1'b0, thr_i};
    r4    = {ediff, 2'b00};
    rc    = (r4 > 27'd8388608) ? 24'd8388608 : r4[23:0];
    cutp  = 34'(max_cut_i * rc) + 34'd4194304;
  end

  // Numerator of the current division and the common divisor.
  always_comb begin
    case (j_q)
      2'd0:    n_sel = $signed({6'd0, a_q}) + $signed({2'b00, aa2_q});
      2'd1:    n_sel = -($signed({{4{csa_q[32]}}, csa_q}) <<< 1);
      2'd2:    n_sel = $signed({6'd0, a_q}) - $signed({2'b00, aa2_q});
      default: n_sel = $signed({6'd0, a_q}) - $signed({3'b000, alpha_i, 3'b000});
    endcase
    n_abs  = n_sel[36] ? -n_sel : n_sel;
    den    = {4'd0, a_q} + {1'b0, alpha_i, 3'b000};
    den_nz = (den == '0) ? 35'd1 : den;
  end

  // One restoring step, then rounding and saturation of the quotient.
  always_comb begin
    rem2 = {rem_q, dvd_q[64]};
    ge   = rem2 >= {1'b0, den_nz};
    up   = {rem_q, 1'b0} >= {1'b0, den_nz};
    qr   = {1'b0, q_q} + 34'(up);
    if (neg_q) begin
      cval = (ovf_q || qr > 34'h0_8000_0000) ? 32'h8000_0000 : -qr[31:0];
    end else begin
      cval = (ovf_q || qr > 34'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : qr[31:0];
    end
  end

  // Control sequence.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      coef_q  <= COEF_RESET;
      done_q  <= 1'b0;
      k_q     <= '0;
      j_q     <= '0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        C_IDLE: begin
          if (start_i) begin
            state_q <= C_CUT;
          end
        end
        C_CUT: begin
          k_q     <= '0;
          state_q <= C_POW;
        end
        C_POW: begin
          k_q <= k_q + 4'd1;
          if (k_q == 4'd8) begin
            state_q <= C_SQ;
          end
        end
        C_SQ:  state_q <= C_AA2;
        C_AA2: state_q <= C_CSA;
        C_CSA: begin
          j_q     <= '0;
          state_q <= C_DLOAD;
        end
        C_DLOAD: begin
          cnt_q   <= '0;
          state_q <= C_DIV;
        end
        C_DIV: begin
          cnt_q <= cnt_q + 7'd1;
          if (cnt_q == 7'(DIV_STEPS - 1)) begin
            state_q <= C_DSTORE;
          end
        end
        C_DSTORE: begin
          case (j_q)
            2'd0: coef_q[0] <= cval;
            2'd1: begin
              coef_q[1] <= cval;
              coef_q[3] <= cval;
            end
            2'd2:    coef_q[2] <= cval;
            default: coef_q[4] <= cval;
          endcase
          j_q <= j_q + 2'd1;
          if (j_q == 2'd3) begin
            done_q  <= 1'b1;
            state_q <= C_IDLE;
          end else begin
            state_q <= C_DLOAD;
          end
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      C_CUT: begin
        cut_q <= (env_i > thr_i) ? cutp[31:23] : 9'd0;
        a_q   <= {1'b0, ONE_Q30[29:0]} | 31'h4000_0000;
      end
      C_POW: begin
        if (cut_q[k_q]) begin
          a_q <= rnd30[30:0];
        end
      end
      C_SQ:  a2_q  <= rnd30[30:0];
      C_AA2: aa2_q <= rnd27[34:0];
      C_CSA: csa_q <= rnd30[32:0];
      C_DLOAD: begin
        dvd_q <= {n_abs[34:0], 30'd0};
        rem_q <= '0;
        q_q   <= '0;
        ovf_q <= 1'b0;
        neg_q <= n_sel[36];
      end
      C_DIV: begin
        dvd_q <= {dvd_q[63:0], 1'b0};
        rem_q <= ge ? 35'(rem2 - {1'b0, den_nz}) : rem2[34:0];
        q_q   <= {q_q[31:0], ge};
        ovf_q <= ovf_q | q_q[32];
      end
      default: ;
    endcase
  end

  assign coef_o = coef_q;
  assign done_o = done_q;

endmodule

// ===== rtl/stereo_de_esser.sv =====
// Top level of the stereo de-esser: configuration registers, item sequencer,
// two filter lanes, the envelope merge and the coefficient unit.
// Depends on sde_pkg, sde_if, sde_lane, sde_merge and sde_coef.
//
//   Port       Direction  Carries
//   req_i      in         sample_left, sample_right (signed Q1.23 pair)
//   res_o      out        out_left, out_right (saturated signed Q1.23 pair)
//   cfg_*_i    in         register writes, index and up to 32 data bits
//
// With a free output an ordinary request passes through an idle state with
// ready high, a sidechain pass in both lanes, an envelope step, a main pass
// and a move into the output register. Each UPDATE_INTERVAL-th request,
// starting with the first after reset, adds a run of the coefficient unit:
// the cut, the gain and its products, and four restoring divisions of 65
// steps, each with a load and a store. A new request is taken while the
// previous result still waits in the output register; a stalled output holds
// the next result in its lane until the register frees. Reset initialises
// the control, configuration, history and coefficient registers only.
module stereo_de_esser import sde_pkg::*; #(
  parameter int UPDATE_INTERVAL = DEF_UPDATE_INTERVAL,
  parameter int ATTACK_COEF     = DEF_ATTACK_COEF,
  parameter int RELEASE_COEF    = DEF_RELEASE_COEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  sde_in_if.sink               req_i,
  sde_out_if.source            res_o
);

  typedef enum logic [5:0] {
    T_IDLE = 6'b000001,
    T_SC   = 6'b000010,
    T_ENV  = 6'b000100,
    T_COEF = 6'b001000,
    T_MAIN = 6'b010000,
    T_PUSH = 6'b100000
  } top_state_e;

  localparam int PH_W = (UPDATE_INTERVAL > 1) ? $clog2(UPDATE_INTERVAL) : 1;

  top_state_e state_q, state_d;
  logic [PH_W-1:0] phase_q;
  logic [29:0] reg_b0_q;
  logic [31:0] reg_a1_q;
  logic [29:0] reg_a2_q;
  logic [31:0] reg_cos_q;
  logic [30:0] reg_alpha_q;
  logic [23:0] reg_thr_q;
  logic [8:0]  reg_cut_q;
  sample_t x_q [2];
  logic out_vld_q;
  sample_t out_l_q, out_r_q;

  logic accept, upd, push;
  lane_ctl_t lane_ctl;
  lane_res_t lane_res [2];
  coef_set_t sc_coef, mn_coef;
  logic [SAMPLE_BITS-1:0] env;
  logic coef_start, coef_done;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_b0_q    <= 30'd289910000;
      reg_a1_q    <= 32'(-459510000);
      reg_a2_q    <= 30'd163320000;
      reg_cos_q   <= 32'd704678000;
      reg_alpha_q <= 31'd25314000;
      reg_thr_q   <= 24'd838861;
      reg_cut_q   <= 9'd100;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SC_B0:     reg_b0_q    <= cfg_data_i[29:0];
        REG_SC_A1:     reg_a1_q    <= cfg_data_i;
        REG_SC_A2:     reg_a2_q    <= cfg_data_i[29:0];
        REG_COS_OMEGA: reg_cos_q   <= cfg_data_i;
        REG_ALPHA:     reg_alpha_q <= cfg_data_i[30:0];
        REG_THRESHOLD: reg_thr_q   <= cfg_data_i[23:0];
        REG_MAX_CUT:   reg_cut_q   <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // Sidechain high-pass set: b2 equals b0, b1 is minus twice b0.
  always_comb begin
    sc_coef[0] = {2'b00, reg_b0_q};
    sc_coef[1] = 32'd0 - {1'b0, reg_b0_q, 1'b0};
    sc_coef[2] = {2'b00, reg_b0_q};
    sc_coef[3] = reg_a1_q;
    sc_coef[4] = {2'b00, reg_a2_q};
  end

  // Item sequencing.
  assign req_i.ready = (state_q == T_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign upd         = (phase_q == '0);
  assign push        = (state_q == T_PUSH) && (!out_vld_q || res_o.ready);
  assign coef_start  = (state_q == T_ENV) && upd;

  always_comb begin
    lane_ctl.start    = accept || ((state_q == T_ENV) && !upd) ||
                        ((state_q == T_COEF) && coef_done);
    lane_ctl.main_sel = (state_q != T_IDLE);
    state_d = state_q;
    unique case (state_q)
      T_IDLE: if (accept) state_d = T_SC;
      T_SC:   if (lane_res[0].done) state_d = T_ENV;
      T_ENV:  state_d = upd ? T_COEF : T_MAIN;
      T_COEF: if (coef_done) state_d = T_MAIN;
      T_MAIN: if (lane_res[0].done) state_d = T_PUSH;
      T_PUSH: if (push) state_d = T_IDLE;
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= T_IDLE;
      phase_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == T_ENV) begin
        phase_q <= (phase_q == PH_W'(UPDATE_INTERVAL - 1)) ? '0 : phase_q + PH_W'(1);
      end
      if (push) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q[0] <= req_i.sample_left;
      x_q[1] <= req_i.sample_right;
    end
    if (push) begin
      out_l_q <= lane_res[0].y;
      out_r_q <= lane_res[1].y;
    end
  end

  assign res_o.valid     = out_vld_q;
  assign res_o.out_left  = out_l_q;
  assign res_o.out_right = out_r_q;

  // Left and right lanes.
  for (genvar g = 0; g < 2; g++) begin : g_lane
    sde_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (lane_ctl),
      .sc_coef_i (sc_coef),
      .mn_coef_i (mn_coef),
      .x_i       (x_q[g]),
      .res_o     (lane_res[g])
    );
  end

  sde_merge #(
    .ATTACK_COEF  (ATTACK_COEF),
    .RELEASE_COEF (RELEASE_COEF)
  ) u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (state_q == T_ENV),
    .yl_i   (lane_res[0].y),
    .yr_i   (lane_res[1].y),
    .env_o  (env)
  );

  sde_coef u_coef (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (coef_start),
    .env_i     (env),
    .thr_i     (reg_thr_q),
    .max_cut_i (reg_cut_q),
    .alpha_i   (reg_alpha_q),
    .cos_i     (reg_cos_q),
    .coef_o    (mn_coef),
    .done_o    (coef_done)
  );

`ifndef ASSERT_OFF
  // Both lanes run in lockstep.
  a_lane_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_res[0].done == lane_res[1].done)
    else $error("lanes out of step");

  // The coefficient unit finishes only while the sequencer waits for it.
  a_coef_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    coef_done |-> state_q == T_COEF)
    else $error("coefficient update finished outside its window");

  // An accepted request starts the sidechain pass.
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == T_SC)
    else $error("accepted request did not start");

  // A pushed result is presented on the next cycle.
  a_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> out_vld_q)
    else $error("result lost at the output register");
`endif

endmodule
